/* rtl/signed_integer_to_decimal_text_unit_macros.svh */
// Assertion macros of the decimal text unit, used by its controller.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SITDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SITDT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sitdt_pkg.sv */
// Package of the decimal text unit: widths, character codes, controller states
// and the control word of the digit cells. Depends on nothing.
`timescale 1ns / 1ps
package sitdt_pkg;
	localparam int VALUE_W = 64;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = 19;
	localparam int BITCNT_W = $clog2(VALUE_W);
	localparam int REM_W    = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic conv;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic sign;
		logic last;
	} emit_t;
endpackage

/* rtl/sitdt_if.sv */
// Request channels of the decimal text unit: signed value in, characters out.
// Depends on sitdt_pkg.
`timescale 1ns / 1ps
interface sitdt_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sitdt_pkg::VALUE_W-1:0] value;
	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface sitdt_out_if;
	logic                          valid;
	logic                          ready;
	logic [sitdt_pkg::CHAR_W-1:0]  character;
	logic                          last;
	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

/* rtl/signed_integer_to_decimal_text_unit.sv */
// Channel  Dir  Payload                Meaning
// din      in   value[63:0] signed     integer to convert
// dout     out  character[7:0], last   ASCII '-' or digit, last on final char
//
// An item is accepted in idle, run by double dabble through the 19-cell chain
// (one magnitude bit per cycle), gives its minus sign if negative, skips leading
// zeros, then gives its digits one per cycle while dout is ready; 1 to 20 chars in all.
// din is ready only in idle; dout stalls hold the chain. Reset clears control.
// Top level; depends on sitdt_pkg, sitdt_if, sitdt_cell and sitdt_ctrl.
`timescale 1ns / 1ps
module signed_integer_to_decimal_text_unit (
	input  logic        clk,
	input  logic        arst_n,
	sitdt_in_if.sink    din,
	sitdt_out_if.source dout
);
	import sitdt_pkg::*;

	cell_ctrl_t         cell_ctrl;
	emit_t              emit;
	logic               ser_bit;
	logic               carry [0:DIGITS];
	logic [DIGIT_W-1:0] digit [0:DIGITS-1];

	sitdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_value  (din.value),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.top_digit (digit[DIGITS-1]),
		.emit      (emit),
		.cell_ctrl (cell_ctrl),
		.ser_bit   (ser_bit)
	);

	assign carry[0] = ser_bit;

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		logic [DIGIT_W-1:0] shift_in;
		if (i == 0) begin : g_first
			assign shift_in = '0;
		end else begin : g_rest
			assign shift_in = digit[i-1];
		end
		sitdt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.carry_in  (carry[i]),
			.shift_in  (shift_in),
			.carry_out (carry[i+1]),
			.digit     (digit[i])
		);
	end

	assign dout.valid     = emit.valid;
	assign dout.last      = emit.last;
	assign dout.character = emit.sign ? CHAR_MINUS
		: CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit[DIGITS-1]};
endmodule

/* rtl/sitdt_cell.sv */
// One decimal digit cell of the double-dabble chain; also shifts digits
// towards the top of the chain for output. Depends on sitdt_pkg.
`timescale 1ns / 1ps
module sitdt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sitdt_pkg::cell_ctrl_t           ctrl,
	input  logic                            carry_in,
	input  logic [sitdt_pkg::DIGIT_W-1:0]   shift_in,
	output logic                            carry_out,
	output logic [sitdt_pkg::DIGIT_W-1:0]   digit
);
	import sitdt_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			priority if (ctrl.clear) begin
				digit_q <= '0;
			end else if (ctrl.conv) begin
				digit_q <= {adj[DIGIT_W-2:0], carry_in};
			end else if (ctrl.shift) begin
				digit_q <= shift_in;
			end else begin
				digit_q <= digit_q;
			end
		end
	end
endmodule

/* rtl/sitdt_ctrl.sv */
// Controller: magnitude register feeding the cell chain bit by bit, sign,
// leading-zero skip and character sequencing. Depends on sitdt_pkg and the macros.
`timescale 1ns / 1ps
`include "signed_integer_to_decimal_text_unit_macros.svh"
module sitdt_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [sitdt_pkg::VALUE_W-1:0]   in_value,
	output logic                            in_ready,
	input  logic                            out_ready,
	input  logic [sitdt_pkg::DIGIT_W-1:0]   top_digit,
	output sitdt_pkg::emit_t                emit,
	output sitdt_pkg::cell_ctrl_t           cell_ctrl,
	output logic                            ser_bit
);
	import sitdt_pkg::*;

	state_t               state_q, state_d;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [BITCNT_W-1:0]  bit_cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 in_fire;
	logic                 skip_zero;

	assign in_fire   = in_valid && in_ready;
	assign skip_zero = (top_digit == '0) && (rem_q > REM_W'(1));
	assign ser_bit   = mag_q[VALUE_W-1];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CONV;
			ST_CONV: if (bit_cnt_q == '0) state_d = neg_q ? ST_SIGN : ST_SKIP;
			ST_SIGN: if (out_ready) state_d = ST_SKIP;
			ST_SKIP: if (!skip_zero) state_d = ST_EMIT;
			ST_EMIT: if (out_ready && rem_q == REM_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		emit            = '0;
		cell_ctrl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cell_ctrl.clear = in_valid;
			end
			ST_CONV: begin
				cell_ctrl.conv = 1'b1;
			end
			ST_SIGN: begin
				emit.valid = 1'b1;
				emit.sign  = 1'b1;
			end
			ST_SKIP: begin
				cell_ctrl.shift = skip_zero;
			end
			ST_EMIT: begin
				emit.valid      = 1'b1;
				emit.last       = (rem_q == REM_W'(1));
				cell_ctrl.shift = out_ready && (rem_q != REM_W'(1));
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			rem_q     <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				neg_q     <= in_value[VALUE_W-1];
				bit_cnt_q <= BITCNT_W'(VALUE_W - 1);
				rem_q     <= REM_W'(DIGITS);
			end else if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q - BITCNT_W'(1);
			end else if (cell_ctrl.shift) begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
	end

	`SITDT_ASSERT_NXT(a_conv_ends, clk, arst_n,
		(state_q == ST_CONV && bit_cnt_q == '0), (state_q != ST_CONV),
		"conversion did not end after the last magnitude bit")
	`SITDT_ASSERT_IMP(a_sign_neg, clk, arst_n,
		(state_q == ST_SIGN), (neg_q),
		"minus sign offered for a non-negative value")
	`SITDT_ASSERT_IMP(a_rem_live, clk, arst_n,
		(state_q == ST_SKIP || state_q == ST_EMIT), (rem_q != '0),
		"digit count ran out while emitting")
	`SITDT_ASSERT_NXT(a_last_idle, clk, arst_n,
		(emit.valid && emit.last && out_ready), (state_q == ST_IDLE),
		"controller did not return to idle after the last character")
endmodule

/* tb/sv/decimal_text_checker.sv */
// Checker for the decimal text unit: watches both request channels, predicts
// the characters of every accepted value and compares them in order.
// Depends on sitdt_pkg and sitdt_if.
`timescale 1ns / 1ps
module decimal_text_checker (
	input  logic clk,
	input  logic arst_n,
	sitdt_in_if  din,
	sitdt_out_if dout,
	output int   mismatches,
	output int   pending
);
	import sitdt_pkg::*;

	localparam logic [VALUE_W-1:0] DECIMAL_BASE = 64'd10;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	text_char_t pending_text[$];
	int         fail_n = 0;

	function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] rem;
		logic [CHAR_W-1:0]  digits[$];
		text_char_t         ch;
		mag = value;
		if (value[VALUE_W-1]) begin
			mag = ~mag + 1'b1;
			ch.character = CHAR_MINUS;
			ch.last = 1'b0;
			pending_text.push_back(ch);
		end
		do begin
			rem = mag % DECIMAL_BASE;
			digits.push_front(CHAR_ZERO + rem[CHAR_W-1:0]);
			mag = mag / DECIMAL_BASE;
		end while (mag != 0);
		for (int i = 0; i < digits.size(); i++) begin
			ch.character = digits[i];
			ch.last = (i == digits.size() - 1);
			pending_text.push_back(ch);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			// drain before predicting: a character never belongs to a request taken at this edge
			if (dout.valid && dout.ready) begin
				if (pending_text.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("%0t: unexpected character %0d last %0b", $realtime,
							dout.character, dout.last);
				end else begin
					want = pending_text.pop_front();
					if (dout.character !== want.character || dout.last !== want.last) begin
						fail_n++;
						if (fail_n <= 10)
							$display("%0t: character %0d/%0d last %0b/%0b (wanted/got)",
								$realtime, want.character, dout.character,
								want.last, dout.last);
					end
				end
			end
			if (din.valid && din.ready)
				predict_decimal_text(din.value);
		end
		mismatches <= fail_n;
		pending <= pending_text.size();
	end
endmodule

/* tb/sv/tb.sv */
// Top of the decimal text unit testbench: clock, reset, value requests and
// character sink with random stalls; verdict from the checker's counts.
// Depends on sitdt_pkg, sitdt_if, decimal_text_checker and the unit itself.
`timescale 1ns / 1ps
module tb;
	import sitdt_pkg::*;

	localparam int ITEMS        = 470;
	localparam int TAIL_ITEMS   = 60;
	localparam int PHASE_ITEMS  = 40;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	bit   source_idle_on;
	bit   sink_stall_on;
	bit   hold_due;
	int   mismatches;
	int   pending;

	sitdt_in_if  din_ch ();
	sitdt_out_if dout_ch ();

	signed_integer_to_decimal_text_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	decimal_text_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din_ch),
		.dout       (dout_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	logic signed [VALUE_W-1:0] directed_values[] = '{
		64'sd0, 64'sd1, -64'sd1, 64'sd9, 64'sd10, -64'sd10, 64'sd99, 64'sd100,
		-64'sd5, 64'sd1234567890123456789, -64'sd1234567890123456789,
		64'sd999999999999999999, 64'sd1000000000000000000,
		-64'sd1000000000000000000, -64'sd9000000000000000000,
		64'sh7fff_ffff_ffff_ffff, 64'sh7fff_ffff_ffff_fffe,
		64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0001,
		64'shaaaa_aaaa_aaaa_aaaa, 64'sh5555_5555_5555_5555
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// character sink: random stalls, one long hold to back the unit up
	initial begin
		dout_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_due) begin
				hold_due = 1'b0;
				dout_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
				dout_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end else begin
				dout_ch.ready <= 1'b1;
			end
		end
	end

	task automatic offer(input logic signed [VALUE_W-1:0] value);
		if (source_idle_on && $urandom_range(0, 2) == 0) begin
			din_ch.valid <= 1'b0;
			// sometimes let the unit go idle first so the gap lands there
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (!din_ch.ready);
				@(negedge clk);
			end
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.value <= value;
		do @(posedge clk); while (!din_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] span;
		int                 digits;
		raw = {$urandom, $urandom};
		span = 1;
		case ($urandom_range(0, 3))
			0: return raw;
			1, 2: begin
				digits = $urandom_range(1, 19);
				repeat (digits) span *= 10;
				raw = raw % span;
			end
			default: begin
				// powers of ten and one below, where the digit count changes
				repeat ($urandom_range(0, 18)) span *= 10;
				raw = span - $urandom_range(0, 1);
			end
		endcase
		if ($urandom_range(0, 1) == 1)
			raw = ~raw + 1'b1;
		return raw;
	endfunction

	initial begin
		din_ch.valid = 1'b0;
		din_ch.value = '0;
		arst_n = 1'b0;
		source_idle_on = 1'b1;
		sink_stall_on = 1'b1;
		hold_due = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_values[i])
			offer(directed_values[i]);

		for (int n = 0; n < ITEMS; n++) begin
			if (n >= ITEMS - TAIL_ITEMS) begin
				source_idle_on = 1'b0;
				sink_stall_on = 1'b0;
			end else if (n % PHASE_ITEMS == 0) begin
				source_idle_on = ($urandom_range(0, 2) != 0);
				sink_stall_on = ($urandom_range(0, 2) != 0);
			end
			if (n == ITEMS / 2)
				hold_due = 1'b1;
			offer(random_value());
		end
		din_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/sitdt_pkg.sv
rtl/sitdt_if.sv
rtl/sitdt_cell.sv
rtl/sitdt_ctrl.sv
rtl/signed_integer_to_decimal_text_unit.sv
tb/sv/decimal_text_checker.sv
tb/sv/tb.sv
